FILE: rtl/palette_fade_engine_unit_assert.svh
// Assertion macros shared by the palette fade engine checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PALETTE_FADE_ENGINE_UNIT_ASSERT_SVH
`define PALETTE_FADE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define PFE_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pfe_pkg.sv
// Shared types, codes and sizes for the palette fade engine.
// No dependencies; imported by every module of the block but pfe_ram.
package pfe_pkg;

	localparam int ENTRIES    = 64;
	localparam int FADE_TICKS = 22;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int ADDR_W     = IDX_W + 1;          // bank bit + entry index
	localparam int MEM_DEPTH  = 2 * ENTRIES;
	localparam int ENTRY_W    = 6;
	localparam int SUM_W      = ((IDX_W > ENTRY_W) ? IDX_W : ENTRY_W) + 1;
	localparam int CNT_W      = $clog2(FADE_TICKS);

	localparam logic [7:0] STEP  = 8'd32;
	localparam logic [7:0] WHITE = 8'd224;

	// item modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;
	localparam logic [1:0] MODE_TICK  = 2'd3;

	// fade kinds on the input
	localparam logic [1:0] KIND_FADE_IN  = 2'd0;
	localparam logic [1:0] KIND_FLASH_IN = 2'd2;

	// active fade codes
	localparam logic [2:0] FADE_NONE = 3'd0;
	localparam logic [2:0] FADE_IN   = 3'd1;
	localparam logic [2:0] FADE_OUT  = 3'd2;
	localparam logic [2:0] FLASH_IN  = 3'd3;

	// sweep operations
	localparam logic [1:0] SW_CLEAR = 2'd0;
	localparam logic [1:0] SW_WHITE = 2'd1;
	localparam logic [1:0] SW_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_FIRST = 2'd0;
	localparam logic [1:0] CFG_EXTRA = 2'd1;
	localparam logic [1:0] CFG_SKIP  = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pfe_rgb_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       bank;
		logic       target_sel;
		logic [5:0] entry;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [1:0] fade_kind;
	} pfe_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       done_res;
	} pfe_out_t;

	// write request into the palette store
	typedef struct packed {
		logic              w_en;
		logic              t_en;
		logic [ADDR_W-1:0] addr;
		pfe_rgb_t          data;
	} pfe_wr_t;

endpackage

FILE: rtl/pfe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/pfe_step.sv
// One sweep step on a palette word: clear, set white, or one fade move.
// Depends on pfe_pkg.
module pfe_step (
	input  logic [1:0]       op,
	input  logic [2:0]       fade,
	input  pfe_pkg::pfe_rgb_t w,
	input  pfe_pkg::pfe_rgb_t t,
	output pfe_pkg::pfe_rgb_t nxt
);
	import pfe_pkg::*;

	always_comb begin
		nxt = w;
		unique case (op)
			SW_CLEAR: nxt = '0;
			SW_WHITE: nxt = '{red: WHITE, green: WHITE, blue: WHITE};
			SW_TICK: begin
				unique case (fade)
					FADE_IN: begin
						// blue first, toward target
						if (t.blue > w.blue)        nxt.blue  = w.blue + STEP;
						else if (t.green > w.green) nxt.green = w.green + STEP;
						else if (t.red > w.red)     nxt.red   = w.red + STEP;
					end
					FADE_OUT: begin
						if (w.red != 8'd0)        nxt.red   = w.red - STEP;
						else if (w.green != 8'd0) nxt.green = w.green - STEP;
						else if (w.blue != 8'd0)  nxt.blue  = w.blue - STEP;
					end
					FLASH_IN: begin
						if (t.blue < w.blue)        nxt.blue  = w.blue - STEP;
						else if (t.green < w.green) nxt.green = w.green - STEP;
						else if (t.red < w.red)     nxt.red   = w.red - STEP;
					end
					default: begin
						// flash-out: red first, toward white
						if (w.red != WHITE)        nxt.red   = w.red + STEP;
						else if (w.green != WHITE) nxt.green = w.green + STEP;
						else if (w.blue != WHITE)  nxt.blue  = w.blue + STEP;
					end
				endcase
			end
			default: nxt = w;
		endcase
	end

endmodule

FILE: rtl/pfe_store.sv
// Palette store: working and target RAMs (both banks) plus per-word valid bits.
// Depends on pfe_pkg and pfe_ram. Unwritten words read as black.
module pfe_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [pfe_pkg::ADDR_W-1:0] raddr,
	input  pfe_pkg::pfe_wr_t          wr,
	output pfe_pkg::pfe_rgb_t         w_rd,
	output pfe_pkg::pfe_rgb_t         t_rd
);
	import pfe_pkg::*;

	logic [MEM_DEPTH-1:0] wval_q;
	logic [MEM_DEPTH-1:0] tval_q;
	logic                 wv_s1;
	logic                 tv_s1;
	logic [23:0]          w_raw;
	logic [23:0]          t_raw;

	pfe_ram #(.WIDTH($bits(pfe_rgb_t)), .DEPTH(MEM_DEPTH)) u_work (
		.clk   (clk),
		.we    (wr.w_en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (w_raw)
	);

	pfe_ram #(.WIDTH($bits(pfe_rgb_t)), .DEPTH(MEM_DEPTH)) u_targ (
		.clk   (clk),
		.we    (wr.t_en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (raddr),
		.rdata (t_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wval_q <= '0;
			tval_q <= '0;
			wv_s1  <= 1'b0;
			tv_s1  <= 1'b0;
		end else begin
			if (wr.w_en) begin
				wval_q[wr.addr] <= 1'b1;
			end
			if (wr.t_en) begin
				tval_q[wr.addr] <= 1'b1;
			end
			wv_s1 <= wval_q[raddr];
			tv_s1 <= tval_q[raddr];
		end
	end

	assign w_rd = wv_s1 ? pfe_rgb_t'(w_raw) : '0;
	assign t_rd = tv_s1 ? pfe_rgb_t'(t_raw) : '0;

endmodule

FILE: rtl/palette_fade_engine_unit.sv
// Palette fade engine top level: control sequencer, sweep pipeline, output register.
// Depends on pfe_pkg, pfe_store and pfe_step.
//
// Usage:
//   in_valid/in_ready/in_data carry one command word (write, read, start fade, tick).
//   out_valid/out_ready/out_data return exactly one result word per command.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the fade-in range and the bank B skip
//   flag; cfg_ready is always high, write only while the engine is idle.
// States from accept to result in the output register:
//   write, start of fade-out/flash-out, tick with no fade active: S_OP, S_FIN.
//   read: S_OP, S_RD, S_FIN. Tick with a fade active, start of fade-in or flash-in:
//   S_OP, S_SWEEP, S_FIN. The sweep runs all 128 words (two banks) through the
//   working RAM's single read and single write port at one word per cycle,
//   read-modify-write, skipping writes outside the range or in an excluded bank B.
// Throughput: one command in flight; the next is taken as soon as the previous
//   result sits in the output register, even while out_ready is low. A stalled
//   receiver holds the result word; a second finished result waits inside.
// Reset: both palettes of both banks read as black, no fade active, tick count zero,
//   fade-in range 0..63, bank B not skipped. No clearing pass is needed.
module palette_fade_engine_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pfe_pkg::pfe_in_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pfe_pkg::pfe_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [5:0]       cfg_data
);
	import pfe_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OP    = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]        state_q;
	pfe_in_t           item_q;
	pfe_out_t          res_q;
	pfe_out_t          out_q;
	logic              out_valid_q;
	logic [2:0]        active_q;
	logic [CNT_W-1:0]  tick_q;
	logic [1:0]        sw_op_q;
	logic [ADDR_W-1:0] sw_q;
	logic [5:0]        first_q;
	logic [5:0]        extra_q;
	logic              skip_q;

	logic              en_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [SUM_W-1:0]  first_x;
	logic [SUM_W-1:0]  last_sum;
	logic [SUM_W-1:0]  last_x;
	logic [SUM_W-1:0]  idx_x;
	logic              in_rng;
	logic              bank_b;
	logic              en_s0;
	logic              entry_ok;
	logic [ADDR_W-1:0] item_addr;
	logic [ADDR_W-1:0] raddr;
	logic              out_free;
	pfe_wr_t           wr;
	pfe_rgb_t          w_rd;
	pfe_rgb_t          t_rd;
	pfe_rgb_t          step_nxt;
	pfe_rgb_t          rd_sel;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	assign item_addr = {item_q.bank, IDX_W'(item_q.entry)};
	assign entry_ok  = SUM_W'(item_q.entry) < SUM_W'(ENTRIES);

	// fade-in range, last entry saturated
	assign first_x  = SUM_W'(first_q);
	assign last_sum = SUM_W'(first_q) + SUM_W'(extra_q);
	assign last_x   = (last_sum > SUM_W'(ENTRIES - 1)) ? SUM_W'(ENTRIES - 1) : last_sum;
	assign idx_x    = SUM_W'(sw_q[IDX_W-1:0]);
	assign bank_b   = sw_q[ADDR_W-1];
	assign in_rng   = (idx_x >= first_x) && (idx_x <= last_x);

	always_comb begin
		en_s0 = 1'b0;
		if (state_q == S_SWEEP) begin
			unique case (sw_op_q)
				SW_CLEAR: en_s0 = !bank_b && in_rng;
				SW_WHITE: en_s0 = !bank_b;
				SW_TICK: begin
					unique case (active_q)
						FADE_IN:  en_s0 = in_rng && (!bank_b || !skip_q);
						FLASH_IN: en_s0 = !bank_b || !skip_q;
						default:  en_s0 = 1'b1;
					endcase
				end
				default: en_s0 = 1'b0;
			endcase
		end
	end

	assign raddr = (state_q == S_SWEEP) ? sw_q : item_addr;

	// sweep write-back has priority; a host write never overlaps a sweep
	always_comb begin
		wr = '0;
		priority if (en_s1) begin
			wr.w_en = 1'b1;
			wr.addr = addr_s1;
			wr.data = step_nxt;
		end else if (state_q == S_OP && item_q.mode == MODE_WRITE && entry_ok) begin
			wr.w_en = !item_q.target_sel;
			wr.t_en = item_q.target_sel;
			wr.addr = item_addr;
			wr.data = '{red: item_q.red_in, green: item_q.green_in, blue: item_q.blue_in};
		end else begin
			wr = '0;
		end
	end

	pfe_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.wr     (wr),
		.w_rd   (w_rd),
		.t_rd   (t_rd)
	);

	pfe_step u_step (
		.op   (sw_op_q),
		.fade (active_q),
		.w    (w_rd),
		.t    (t_rd),
		.nxt  (step_nxt)
	);

	assign rd_sel = item_q.target_sel ? t_rd : w_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			extra_q <= 6'd63;
			skip_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST: first_q <= cfg_data;
				CFG_EXTRA: extra_q <= cfg_data;
				CFG_SKIP:  skip_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1   <= 1'b0;
			addr_s1 <= '0;
		end else begin
			en_s1   <= en_s0;
			addr_s1 <= sw_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			active_q    <= FADE_NONE;
			tick_q      <= '0;
			sw_op_q     <= SW_TICK;
			sw_q        <= '0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= S_OP;
					end
				end
				S_OP: begin
					// only a tick with no fade running answers done from here
					res_q <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
						done_res: (item_q.mode == MODE_TICK) && (active_q == FADE_NONE)};
					sw_q  <= '0;
					unique case (item_q.mode)
						MODE_WRITE: state_q <= S_FIN;
						MODE_READ:  state_q <= S_RD;
						MODE_START: begin
							active_q <= 3'({1'b0, item_q.fade_kind}) + 3'd1;
							tick_q   <= '0;
							if (item_q.fade_kind == KIND_FADE_IN) begin
								sw_op_q <= SW_CLEAR;
								state_q <= S_SWEEP;
							end else if (item_q.fade_kind == KIND_FLASH_IN) begin
								sw_op_q <= SW_WHITE;
								state_q <= S_SWEEP;
							end else begin
								state_q <= S_FIN;
							end
						end
						default: begin
							if (active_q == FADE_NONE) begin
								state_q <= S_FIN;
							end else begin
								sw_op_q <= SW_TICK;
								state_q <= S_SWEEP;
							end
						end
					endcase
				end
				S_RD: begin
					res_q.red_out   <= entry_ok ? rd_sel.red : 8'd0;
					res_q.green_out <= entry_ok ? rd_sel.green : 8'd0;
					res_q.blue_out  <= entry_ok ? rd_sel.blue : 8'd0;
					res_q.done_res  <= 1'b0;
					state_q         <= S_FIN;
				end
				S_SWEEP: begin
					sw_q <= sw_q + ADDR_W'(1);
					if (sw_q == '1) begin
						// last word read; its write-back lands during S_FIN
						if (sw_op_q == SW_TICK) begin
							if (tick_q == CNT_W'(FADE_TICKS - 1)) begin
								tick_q         <= '0;
								res_q.done_res <= 1'b1;
							end else begin
								tick_q <= tick_q + CNT_W'(1);
							end
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/pfe_checker.sv
// Port-level checker for palette_fade_engine_unit, attached by bind.
// Depends on pfe_pkg and palette_fade_engine_unit_assert.svh.
`include "palette_fade_engine_unit_assert.svh"

module pfe_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input pfe_pkg::pfe_in_t  in_data,
	input logic             out_valid,
	input logic             out_ready,
	input pfe_pkg::pfe_out_t out_data,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [1:0]       cfg_index,
	input logic [5:0]       cfg_data
);
	import pfe_pkg::*;

	logic in_acc;
	logic cfg_seen;

	assign in_acc   = in_valid && in_ready;
	assign cfg_seen = cfg_valid || (cfg_index != 2'd0) || (cfg_data != 6'd0) || cfg_ready
		|| (in_data.mode == MODE_WRITE);

	// result word held until taken
	`PFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	// one command in flight
	`PFE_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_acc, !in_ready, "second command word taken before the first finished")
	// no result word can appear in the cycle after a command word is taken
	`PFE_ASSERT_NEXT(a_min_latency, clk, arst_n, in_acc && cfg_seen, !$rose(out_valid), "result word too early")
	// a done result never carries color
	`PFE_ASSERT_NOW(a_done_black, clk, arst_n, out_valid && out_data.done_res, out_data.red_out == 8'd0 && out_data.green_out == 8'd0 && out_data.blue_out == 8'd0, "done result with nonzero color")

endmodule

bind palette_fade_engine_unit pfe_checker u_pfe_checker (.*);

FILE: bench/tb_palette_fade_engine_unit.sv
// Self-checking bench for palette_fade_engine_unit: directed and random command words,
// checked one by one against a palette and fade tracker kept inside the bench.
// Depends on pfe_pkg and the palette_fade_engine_unit RTL.
`timescale 1ns / 100ps

module tb_palette_fade_engine_unit;
	import pfe_pkg::*;

	// fade kinds the package leaves out
	localparam logic [1:0] KIND_FADE_OUT  = 2'd1;
	localparam logic [1:0] KIND_FLASH_OUT = 2'd3;
	localparam int SETTLE_CYCLES = 140;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pfe_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	pfe_out_t out_data;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	palette_fade_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// palette and fade tracker
	pfe_rgb_t   pal_work [2][ENTRIES];
	pfe_rgb_t   pal_goal [2][ENTRIES];
	logic [2:0] fade_now;
	int         tick_tally;
	logic [5:0] range_first;
	logic [5:0] range_extra;
	logic       skip_b;

	pfe_out_t due_results[$];
	int       errors;
	int       items_sent;
	int       send_idle;
	int       recv_idle;
	int       hold_req;
	int       hold_left;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#40_000_000;
		$display("tb_palette_fade_engine_unit: errors");
		$finish;
	end

	function automatic pfe_rgb_t nudge(logic [2:0] fade, pfe_rgb_t w, pfe_rgb_t t);
		pfe_rgb_t r;
		r = w;
		case (fade)
			FADE_IN: begin
				if (t.blue > w.blue) r.blue = w.blue + STEP;
				else if (t.green > w.green) r.green = w.green + STEP;
				else if (t.red > w.red) r.red = w.red + STEP;
			end
			FLASH_IN: begin
				if (t.blue < w.blue) r.blue = w.blue - STEP;
				else if (t.green < w.green) r.green = w.green - STEP;
				else if (t.red < w.red) r.red = w.red - STEP;
			end
			FADE_OUT: begin
				if (w.red != 8'd0) r.red = w.red - STEP;
				else if (w.green != 8'd0) r.green = w.green - STEP;
				else if (w.blue != 8'd0) r.blue = w.blue - STEP;
			end
			default: begin
				if (w.red != WHITE) r.red = w.red + STEP;
				else if (w.green != WHITE) r.green = w.green + STEP;
				else if (w.blue != WHITE) r.blue = w.blue + STEP;
			end
		endcase
		return r;
	endfunction

	// Applies one command to the tracker and returns the word the block must answer with.
	function automatic pfe_out_t predict_word(pfe_in_t w);
		pfe_out_t r;
		pfe_rgb_t c;
		int lo, hi, b, i;
		r = '0;
		hi = int'(range_first) + int'(range_extra);
		if (hi > ENTRIES - 1) hi = ENTRIES - 1;
		case (w.mode)
			MODE_WRITE: begin
				c = {w.red_in, w.green_in, w.blue_in};
				if (w.target_sel) pal_goal[w.bank][w.entry] = c;
				else pal_work[w.bank][w.entry] = c;
			end
			MODE_READ: begin
				c = w.target_sel ? pal_goal[w.bank][w.entry] : pal_work[w.bank][w.entry];
				r.red_out   = c.red;
				r.green_out = c.green;
				r.blue_out  = c.blue;
			end
			MODE_START: begin
				if (w.fade_kind == KIND_FADE_IN) begin
					for (i = range_first; i <= hi; i++) pal_work[0][i] = '0;
				end else if (w.fade_kind == KIND_FLASH_IN) begin
					for (i = 0; i < ENTRIES; i++) pal_work[0][i] = {WHITE, WHITE, WHITE};
				end
				fade_now = {1'b0, w.fade_kind} + 3'd1;
				tick_tally = 0;
			end
			default: begin
				if (fade_now == FADE_NONE) begin
					r.done_res = 1'b1;
				end else begin
					lo = 0;
					if (fade_now == FADE_IN) lo = range_first;
					else hi = ENTRIES - 1;
					for (b = 0; b < 2; b++) begin
						// bank B sits out the toward-target fades when skipped
						if (b == 1 && skip_b && (fade_now == FADE_IN || fade_now == FLASH_IN))
							continue;
						for (i = lo; i <= hi; i++)
							pal_work[b][i] = nudge(fade_now, pal_work[b][i], pal_goal[b][i]);
					end
					tick_tally++;
					if (tick_tally >= FADE_TICKS) begin
						tick_tally = 0;
						r.done_res = 1'b1;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		pfe_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("word with nothing pending", out_data, 0);
			end else begin
				want = due_results.pop_front();
				if (out_data.red_out != want.red_out)
					report_mismatch("red_out", out_data.red_out, want.red_out);
				if (out_data.green_out != want.green_out)
					report_mismatch("green_out", out_data.green_out, want.green_out);
				if (out_data.blue_out != want.blue_out)
					report_mismatch("blue_out", out_data.blue_out, want.blue_out);
				if (out_data.done_res != want.done_res)
					report_mismatch("done_res", out_data.done_res, want.done_res);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic offer_word(input pfe_in_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = w;
		do @(posedge clk); while (!in_ready);
		due_results.push_back(predict_word(w));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FIRST: range_first = val;
			CFG_EXTRA: range_extra = val;
			CFG_SKIP:  skip_b = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic pfe_in_t cmd(logic [1:0] mode, logic bank, logic tsel, logic [5:0] entry,
			logic [23:0] rgb, logic [1:0] kind);
		pfe_in_t w;
		w = {mode, bank, tsel, entry, rgb, kind};
		return w;
	endfunction

	function automatic pfe_in_t rand_word();
		pfe_in_t w;
		w = pfe_in_t'(36'({$urandom, $urandom}));
		return w;
	endfunction

	// half the channels on the 32 grid so fades settle on their targets
	function automatic logic [7:0] rand_chan();
		if ($urandom_range(1) == 0) return 8'($urandom_range(7) * 32);
		return 8'($urandom);
	endfunction

	task automatic test_idle_tick();
		offer_word(cmd(MODE_TICK, 1'b0, 1'b0, 6'd0, 24'h0, KIND_FADE_IN));
		offer_word(cmd(MODE_READ, 1'b1, 1'b1, 6'd63, 24'hffffff, KIND_FLASH_OUT));
	endtask

	task automatic test_write_read();
		offer_word(cmd(MODE_WRITE, 1'b0, 1'b0, 6'd0, 24'hffffff, KIND_FADE_IN));
		offer_word(cmd(MODE_WRITE, 1'b1, 1'b1, 6'd63, 24'h8001fe, KIND_FLASH_OUT));
		offer_word(cmd(MODE_WRITE, 1'b0, 1'b1, 6'd63, 24'he0a060, KIND_FADE_OUT));
		offer_word(cmd(MODE_WRITE, 1'b1, 1'b0, 6'd0, 24'h204000, KIND_FLASH_IN));
		offer_word(cmd(MODE_READ, 1'b0, 1'b0, 6'd0, 24'h0, KIND_FADE_IN));
		offer_word(cmd(MODE_READ, 1'b1, 1'b1, 6'd63, 24'h0, KIND_FADE_IN));
		offer_word(cmd(MODE_READ, 1'b0, 1'b1, 6'd63, 24'h0, KIND_FADE_IN));
		offer_word(cmd(MODE_READ, 1'b1, 1'b0, 6'd0, 24'h0, KIND_FADE_IN));
	endtask

	task automatic test_each_fade();
		logic [1:0] k;
		k = KIND_FADE_IN;
		repeat (4) begin
			offer_word(cmd(MODE_START, 1'b0, 1'b0, 6'd0, 24'h0, k));
			offer_word(cmd(MODE_TICK, 1'b1, 1'b1, 6'd63, 24'hffffff, k));
			offer_word(cmd(MODE_READ, 1'b0, 1'b0, 6'd63, 24'h0, k));
			k++;
		end
	endtask

	// receiver holds off while words keep coming, so the input has to back up
	task automatic test_backpressure();
		pfe_in_t w;
		wait_drained();
		hold_req = 300;
		repeat (12) begin
			w = rand_word();
			w.mode = ($urandom_range(1) == 0) ? MODE_WRITE : MODE_READ;
			offer_word(w);
		end
		wait_drained();
	endtask

	task automatic random_reg_write();
		logic [1:0] idx;
		logic [5:0] val;
		idx = 2'($urandom_range(2));
		case ($urandom_range(3))
			0: val = 6'd0;
			1: val = 6'd63;
			default: val = 6'($urandom);
		endcase
		write_reg(idx, val);
	endtask

	// maybe rewrite a register, set up palettes, start a fade, tick through it with reads and random words mixed in
	task automatic run_fade_sequence();
		pfe_in_t w;
		int n;
		if ($urandom_range(4) == 0) random_reg_write();
		n = $urandom_range(6);
		repeat (n) begin
			w = rand_word();
			w.mode = MODE_WRITE;
			w.red_in = rand_chan();
			w.green_in = rand_chan();
			w.blue_in = rand_chan();
			offer_word(w);
		end
		w = rand_word();
		w.mode = MODE_START;
		offer_word(w);
		n = $urandom_range(25);
		repeat (n) begin
			if ($urandom_range(5) == 0) begin
				w = rand_word();
				w.mode = MODE_READ;
				offer_word(w);
			end
			if ($urandom_range(9) == 0) offer_word(rand_word());
			w = rand_word();
			w.mode = MODE_TICK;
			offer_word(w);
		end
		n = $urandom_range(1, 4);
		repeat (n) begin
			w = rand_word();
			w.mode = MODE_READ;
			offer_word(w);
		end
	endtask

	task automatic test_random(input int goal);
		while (items_sent < goal) run_fade_sequence();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		hold_req = 0;
		hold_left = 0;
		send_idle = 9;
		recv_idle = 72;
		fade_now = FADE_NONE;
		tick_tally = 0;
		range_first = 6'd0;
		range_extra = 6'd63;
		skip_b = 1'b0;
		for (int b = 0; b < 2; b++) begin
			for (int i = 0; i < ENTRIES; i++) begin
				pal_work[b][i] = '0;
				pal_goal[b][i] = '0;
			end
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_idle_tick();
		test_write_read();
		test_each_fade();

		write_reg(CFG_FIRST, 6'd63);
		write_reg(CFG_EXTRA, 6'd63);
		write_reg(CFG_SKIP, 6'd1);
		test_random(340);

		send_idle = 72;
		recv_idle = 9;
		write_reg(CFG_FIRST, 6'd0);
		write_reg(CFG_EXTRA, 6'd0);
		write_reg(CFG_SKIP, 6'd0);
		test_random(660);

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_FIRST, 6'd20);
		write_reg(CFG_EXTRA, 6'd10);
		write_reg(CFG_SKIP, 6'd1);
		test_backpressure();
		test_random(950);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch("words never returned", due_results.size(), 0);
		if (errors == 0)
			$display("tb_palette_fade_engine_unit: clean");
		else
			$display("tb_palette_fade_engine_unit: errors");
		$finish;
	end

endmodule
